>>> src/rwmma_pkg.sv
package rwmma_pkg;

	localparam int DATA_W            = 32;
	localparam int SIZE_W            = 11;
	localparam int WINDOW_DEPTH      = 1024;
	localparam int WINDOW_SIZE_RESET = 600;

	localparam int ADDR_W    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
	localparam int SUM_W     = DATA_W + ADDR_W;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [SIZE_W-1:0]        size_t;

endpackage

>>> src/rwmma_ram.sv
module rwmma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> src/rolling_window_min_max_avg.sv
// Rolling window minimum, maximum and mean of signed power samples.
//
// Input channel (in_valid / in_ready) carries one sample and its valid flag
// per beat. Every input beat produces exactly one result beat on the output
// channel (out_valid / out_ready): window minimum, maximum, mean, sample count
// and a has-data flag. A sample flagged invalid changes nothing and repeats
// the last results once the output register is free.
// A valid sample is written into the ring memory, then all held entries are
// read back one per cycle through the single-port memory, then the mean is
// formed by a restoring divider that settles one quotient bit per cycle.
// One item is in work at a time.
// The config channel (cfg_valid / cfg_ready) writes window_size; it is taken
// only while no item is in work and no result waits, and it empties the window.
// Reset sets window_size to 600 and empties the window; the memory needs no
// clearing since an entry is read only after it was written.
// While the receiver stalls, a finished result holds in the output register
// and the block still takes and works on the next item, holding its result
// until the output register frees.
module rolling_window_min_max_avg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  rwmma_pkg::size_t   window_size,
	input  logic               in_valid,
	output logic               in_ready,
	input  rwmma_pkg::sample_t sample,
	input  logic               sample_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output rwmma_pkg::sample_t window_min,
	output rwmma_pkg::sample_t window_max,
	output rwmma_pkg::sample_t window_mean,
	output rwmma_pkg::size_t   sample_count,
	output logic               has_data
);

	import rwmma_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]           state_q;
	size_t                wsize_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic signed [SUM_W-1:0] sum_q;
	sample_t              held_min_q, held_max_q, held_mean_q;
	sample_t              sample_q;
	logic                 repl_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic                 scan_pend_s1;
	logic                 scan_first_q;
	sample_t              min_q, max_q;
	logic [CNT_W-1:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic                 div_neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	sample_t              out_min_q, out_max_q, out_mean_q;
	size_t                out_count_q;
	logic                 out_has_q;

	logic [CMP_W-1:0]     eff_size;
	logic                 full;
	logic [ADDR_W-1:0]    ptr_wrap;
	logic [ADDR_W-1:0]    ptr_next;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_addr;
	logic [DATA_W-1:0]    ram_rdata;
	sample_t              rd_val;
	logic                 scan_issue;
	logic                 in_acc, cfg_acc, out_load;
	logic [CNT_W:0]       div_trial;
	logic                 div_bit;
	logic [CNT_W-1:0]     rem_next;
	logic [SUM_W-1:0]     quo_next;
	logic [SUM_W-1:0]     sum_mag;
	logic signed [SUM_W-1:0] old_ext;

	// window_size of zero acts as one, above the depth acts as the depth
	always_comb begin
		if (wsize_q == '0) begin
			eff_size = CMP_W'(1);
		end else if (CMP_W'(wsize_q) > CMP_W'(WINDOW_DEPTH)) begin
			eff_size = CMP_W'(WINDOW_DEPTH);
		end else begin
			eff_size = CMP_W'(wsize_q);
		end
	end

	assign full     = CMP_W'(fill_q) >= eff_size;
	assign ptr_wrap = (CMP_W'(ptr_q) >= eff_size) ? '0 : ptr_q;
	assign ptr_next = ((CMP_W'(ptr_q) + CMP_W'(1)) >= eff_size) ? '0 : ptr_q + 1'b1;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid && !out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign scan_issue = (state_q == S_SCAN) && (scan_idx_q < fill_q);
	assign rd_val     = sample_t'(ram_rdata);

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = ptr_wrap;
		case (state_q)
			S_WRITE: begin
				ram_we   = 1'b1;
				ram_addr = repl_q ? ptr_q : fill_q[ADDR_W-1:0];
			end
			S_SCAN: begin
				ram_addr = scan_idx_q[ADDR_W-1:0];
			end
			default: begin
				ram_addr = ptr_wrap;
			end
		endcase
	end

	rwmma_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample_q),
		.rdata(ram_rdata)
	);

	assign old_ext = repl_q ? SUM_W'(rd_val) : '0;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign div_trial = {rem_q, quo_q[SUM_W-1]};
	assign div_bit   = div_trial >= {1'b0, fill_q};
	assign rem_next  = div_bit ? CNT_W'(div_trial - {1'b0, fill_q}) : div_trial[CNT_W-1:0];
	assign quo_next  = {quo_q[SUM_W-2:0], div_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wsize_q      <= SIZE_W'(WINDOW_SIZE_RESET);
			ptr_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			held_min_q   <= '0;
			held_max_q   <= '0;
			held_mean_q  <= '0;
			out_valid_q  <= 1'b0;
			scan_pend_s1 <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!sample_valid) begin
							state_q <= S_DONE;
						end else begin
							sample_q <= sample;
							repl_q   <= full;
							if (full) begin
								ptr_q <= ptr_wrap;
							end
							state_q <= S_WRITE;
						end
					end else if (cfg_acc) begin
						wsize_q     <= window_size;
						ptr_q       <= '0;
						fill_q      <= '0;
						sum_q       <= '0;
						held_min_q  <= '0;
						held_max_q  <= '0;
						held_mean_q <= '0;
					end
				end
				S_WRITE: begin
					sum_q <= sum_q - old_ext + SUM_W'(sample_q);
					if (repl_q) begin
						ptr_q <= ptr_next;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					scan_idx_q   <= '0;
					scan_first_q <= 1'b1;
					scan_pend_s1 <= 1'b0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					scan_pend_s1 <= scan_issue;
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (scan_pend_s1) begin
						scan_first_q <= 1'b0;
						if (scan_first_q || rd_val < min_q) begin
							min_q <= rd_val;
						end
						if (scan_first_q || rd_val > max_q) begin
							max_q <= rd_val;
						end
					end
					// last read data came back this cycle
					if (scan_pend_s1 && !scan_issue) begin
						quo_q     <= sum_mag;
						rem_q     <= '0;
						div_neg_q <= sum_q[SUM_W-1];
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= rem_next;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
						held_min_q  <= min_q;
						held_max_q  <= max_q;
						held_mean_q <= div_neg_q ? DATA_W'(-quo_next) : DATA_W'(quo_next);
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_min_q   <= held_min_q;
						out_max_q   <= held_max_q;
						out_mean_q  <= held_mean_q;
						out_count_q <= SIZE_W'(fill_q);
						out_has_q   <= fill_q != '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign window_min   = out_min_q;
	assign window_max   = out_max_q;
	assign window_mean  = out_mean_q;
	assign sample_count = out_count_q;
	assign has_data     = out_has_q;

endmodule

>>> src/rwmma_check.sv
module rwmma_check (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input rwmma_pkg::sample_t window_min,
	input rwmma_pkg::sample_t window_max,
	input rwmma_pkg::sample_t window_mean,
	input rwmma_pkg::size_t   sample_count,
	input logic               has_data
);

	import rwmma_pkg::*;

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_min)
			&& $stable(window_max) && $stable(window_mean) && $stable(sample_count))
		else $error("result changed while stalled");

	a_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_data == (sample_count != '0))
		else $error("has_data disagrees with sample_count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> window_min == '0 && window_max == '0
			&& window_mean == '0)
		else $error("empty window reports nonzero values");

	// the mean of the window lies between its extremes
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_data |-> window_min <= window_mean && window_mean <= window_max)
		else $error("mean outside min and max");

endmodule

bind rolling_window_min_max_avg rwmma_check u_rwmma_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.window_min  (window_min),
	.window_max  (window_max),
	.window_mean (window_mean),
	.sample_count(sample_count),
	.has_data    (has_data)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rwmma_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int RANDOM_BEATS = 540;

	typedef struct {
		sample_t smp;
		logic    vld;
	} power_beat_t;

	typedef struct {
		sample_t mn;
		sample_t mx;
		sample_t mean;
		size_t   cnt;
		logic    has;
	} window_stats_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	size_t   window_size = '0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample = '0;
	logic    sample_valid = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t window_min;
	sample_t window_max;
	sample_t window_mean;
	size_t   sample_count;
	logic    has_data;

	rolling_window_min_max_avg u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_size  (window_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.sample_valid (sample_valid),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_min   (window_min),
		.window_max   (window_max),
		.window_mean  (window_mean),
		.sample_count (sample_count),
		.has_data     (has_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the window
	size_t   win_size_q = size_t'(WINDOW_SIZE_RESET);
	sample_t win_store [WINDOW_DEPTH];
	int      win_fill = 0;
	int      win_oldest = 0;
	longint  win_sum = 0;
	sample_t held_min = '0;
	sample_t held_max = '0;
	sample_t held_mean = '0;

	power_beat_t   pending_beats [$];
	window_stats_t expected_stats [$];

	int n_errors = 0;
	int n_items = 0;
	int n_missing = 0;
	int n_results = 0;
	int n_settings = 0;
	int cycle_cnt = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	function automatic void clear_window();
		win_fill = 0;
		win_oldest = 0;
		win_sum = 0;
		held_min = '0;
		held_max = '0;
		held_mean = '0;
	endfunction

	function automatic window_stats_t advance_window(input power_beat_t b);
		window_stats_t r;
		int eff;
		int i;
		sample_t lo;
		sample_t hi;
		eff = int'(win_size_q);
		if (eff < 1)
			eff = 1;
		if (eff > WINDOW_DEPTH)
			eff = WINDOW_DEPTH;
		if (b.vld) begin
			if (win_fill < eff) begin
				win_store[win_fill] = b.smp;
				win_sum += longint'(b.smp);
				win_fill++;
			end else begin
				if (win_oldest >= eff)
					win_oldest = 0;
				win_sum -= longint'(win_store[win_oldest]);
				win_store[win_oldest] = b.smp;
				win_sum += longint'(b.smp);
				win_oldest++;
				if (win_oldest >= eff)
					win_oldest = 0;
			end
			lo = win_store[0];
			hi = win_store[0];
			for (i = 1; i < win_fill; i++) begin
				if (win_store[i] < lo)
					lo = win_store[i];
				if (win_store[i] > hi)
					hi = win_store[i];
			end
			held_min = lo;
			held_max = hi;
			// signed division truncates toward zero
			held_mean = sample_t'(win_sum / longint'(win_fill));
		end
		r.mn = held_min;
		r.mx = held_max;
		r.mean = held_mean;
		r.cnt = size_t'(win_fill);
		r.has = (win_fill != 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [63:0] got,
			input logic signed [63:0] want);
		n_errors++;
		$display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
	endtask

	// sender
	always @(posedge clk) begin : drive_proc
		bit offering;
		power_beat_t cur_beat;
		int gap_left;
		if (arst_n) begin
			offering = in_valid;
			if (in_valid && in_ready) begin
				expected_stats = {expected_stats, advance_window(cur_beat)};
				n_items++;
				if (!cur_beat.vld)
					n_missing++;
				gap_left = send_burst ? 0 : $urandom_range(0, 15);
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					cur_beat = pending_beats.pop_front();
					sample <= cur_beat.smp;
					sample_valid <= cur_beat.vld;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin : watch_proc
		window_stats_t want;
		int stall_left;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					report_mismatch("result with nothing expected", 0, 0);
				end else begin
					want = expected_stats.pop_front();
					if (window_min !== want.mn)
						report_mismatch("window_min", window_min, want.mn);
					if (window_max !== want.mx)
						report_mismatch("window_max", window_max, want.mx);
					if (window_mean !== want.mean)
						report_mismatch("window_mean", window_mean, want.mean);
					if (sample_count !== want.cnt)
						report_mismatch("sample_count", sample_count, want.cnt);
					if (has_data !== want.has)
						report_mismatch("has_data", has_data, want.has);
				end
				n_results++;
				stall_left = recv_burst ? 0 : $urandom_range(0, 15);
			end
			if (stall_left == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				// count the stall down while a result is waiting
				if (out_valid)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic push_beat(input sample_t s, input logic v);
		power_beat_t b;
		b.smp = s;
		b.vld = v;
		pending_beats = {pending_beats, b};
	endtask

	task automatic push_random_beat();
		sample_t s;
		case ($urandom_range(0, 9))
			0: s = 32'sh8000_0000;
			1: s = 32'sh7fff_ffff;
			2, 3: s = sample_t'(int'($urandom_range(0, 32)) - 16);
			4: s = -32'sd1;
			default: s = sample_t'($urandom());
		endcase
		push_beat(s, $urandom_range(0, 6) != 0);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_stats.size() != 0);
	endtask

	// empties the window, so only once all results are back
	task automatic start_setting(input size_t v);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		window_size <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_size_q = v;
		clear_window();
		n_settings++;
		send_burst = ($urandom_range(0, 3) == 0);
		recv_burst = ($urandom_range(0, 3) == 0);
	endtask

	initial begin : main_seq
		int sent;
		int len;
		int n;
		int i;
		bit split;
		size_t sz;
		clear_window();
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset window of 600, starting empty
		push_beat('0, 1'b0);
		push_beat(-32'sd1, 1'b0);
		push_beat(32'sh7fff_ffff, 1'b1);
		push_beat(32'sh8000_0000, 1'b1);
		push_beat(-32'sd1, 1'b1);
		push_beat(32'sh8000_0000, 1'b0);
		push_beat('0, 1'b1);
		push_beat(32'sd1, 1'b1);

		// two entry ring, negative means truncate toward zero
		start_setting(size_t'(2));
		push_beat(-32'sd1, 1'b1);
		push_beat(-32'sd2, 1'b1);
		push_beat(-32'sd4, 1'b1);
		push_beat(32'sd5, 1'b1);
		push_beat('0, 1'b0);

		// zero acts as one
		start_setting('0);
		push_beat(32'sd5, 1'b1);
		push_beat(-32'sd7, 1'b1);
		push_beat('0, 1'b0);

		// above depth clamps to depth, sum grows past 32 bits
		start_setting('1);
		push_beat(32'sh7fff_ffff, 1'b1);
		push_beat(32'sh7fff_ffff, 1'b1);
		push_beat(32'sh7fff_ffff, 1'b1);
		push_beat(32'sh8000_0000, 1'b1);
		push_beat('0, 1'b0);

		start_setting(size_t'(WINDOW_DEPTH));
		push_beat(-32'sd9, 1'b1);
		push_beat(32'sd3, 1'b1);
		push_beat(32'sh8000_0000, 1'b1);

		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: begin
					sz = size_t'($urandom_range(0, 2047));
					len = $urandom_range(10, 25);
				end
				1: begin
					sz = size_t'($urandom_range(60, 120));
					len = int'(sz) + $urandom_range(10, int'(sz) / 2);
				end
				default: begin
					sz = size_t'($urandom_range(1, 16));
					len = $urandom_range(15, 40);
				end
			endcase
			if (len > RANDOM_BEATS - sent)
				len = RANDOM_BEATS - sent;
			split = (sent == 0) || ($urandom_range(0, 3) == 0);
			start_setting(sz);
			n = split ? len / 2 : len;
			for (i = 0; i < n; i++)
				push_random_beat();
			if (split) begin
				// hold the sender until the block has drained
				wait_idle();
				for (i = n; i < len; i++)
					push_random_beat();
			end
			sent += len;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_stats.size() != 0)
			report_mismatch("results never delivered", 0, expected_stats.size());
		$display("ran %0d sample beats (%0d missing) over %0d window settings",
			n_items, n_missing, n_settings + 1);
		$display("checked %0d results with random sender gaps and receiver stalls", n_results);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
